// File: rtl/pspm_pkg.sv
// pspm_pkg: shared types, constants and the arctangent table of the pie-sector mask.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pspm_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int PRESCALE     = 20;

  localparam int DIM_W    = 11;
  localparam int PIX_W    = 10;
  localparam int PCT_W    = 7;
  localparam int FRAC_W   = 16;
  // doubled coordinates span -2047..2047
  localparam int COORD_W  = PIX_W + 3;
  // prescaled vector with CORDIC gain
  localparam int DATA_W   = COORD_W + PRESCALE + 1;
  localparam int TURN_W   = 32;
  localparam int SHIFT_W  = $clog2(CORDIC_STEPS);
  localparam int LATENCY  = CORDIC_STEPS + 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_USED_PERCENT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_BELOW   = CFG_IDX_W'(3);

  localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic              keep;
    logic [FRAC_W-1:0] turn_fraction;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [PCT_W-1:0] used_percent;
    logic             keep_below;
  } cfg_t;

  // one slot of the rotation chain
  typedef struct packed {
    logic                     valid;
    logic                     bypass;
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
    logic [TURN_W-1:0]        z;
  } stage_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TURN_W-1:0] atan_turn(input int idx);
    logic [TURN_W-1:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pspm_prep.sv
// pspm_prep: centres the pixel, handles the axes and the half-turn pre-rotation.
// Depends on pspm_pkg; feeds the first rotation cell.
`default_nettype none
module pspm_prep (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire pspm_pkg::pixel_t pixel,
  input  wire pspm_pkg::cfg_t   cfg,
  output pspm_pkg::stage_t      out
);

  localparam int CW = pspm_pkg::COORD_W;
  localparam int PAD = pspm_pkg::DATA_W - CW - pspm_pkg::PRESCALE;

  logic [pspm_pkg::DIM_W-1:0] w;
  logic [pspm_pkg::DIM_W-1:0] h;
  logic signed [CW-1:0]       ex;
  logic signed [CW-1:0]       ey;
  logic signed [CW-1:0]       uc;
  logic signed [CW-1:0]       vc;
  pspm_pkg::stage_t           out_next;

  always_comb begin
    w = (cfg.image_width > pspm_pkg::DIM_W'(pspm_pkg::MAX_DIM)) ?
        pspm_pkg::DIM_W'(pspm_pkg::MAX_DIM) : cfg.image_width;
    h = (cfg.image_height > pspm_pkg::DIM_W'(pspm_pkg::MAX_DIM)) ?
        pspm_pkg::DIM_W'(pspm_pkg::MAX_DIM) : cfg.image_height;
    ex = $signed({2'b00, pixel.pixel_x, 1'b1}) - $signed({2'b00, w});
    ey = $signed({2'b00, h}) - $signed({2'b00, pixel.pixel_y, 1'b1});

    out_next.valid  = accept;
    out_next.bypass = 1'b0;
    out_next.z      = '0;
    uc = ey;
    vc = ex;
    if (ex == '0) begin
      out_next.bypass = 1'b1;
      out_next.z      = ey[CW-1] ? pspm_pkg::TURN_HALF : '0;
    end else if (ey == '0) begin
      out_next.bypass = 1'b1;
      out_next.z      = (!ex[CW-1]) ? pspm_pkg::TURN_QUARTER :
                        (pspm_pkg::TURN_HALF + pspm_pkg::TURN_QUARTER);
    end else if (ey[CW-1]) begin
      // rotate by a half turn so the vector sits in the right half-plane
      uc = -ey;
      vc = -ex;
      out_next.z = pspm_pkg::TURN_HALF;
    end
    out_next.u = {{PAD{uc[CW-1]}}, uc, {pspm_pkg::PRESCALE{1'b0}}};
    out_next.v = {{PAD{vc[CW-1]}}, vc, {pspm_pkg::PRESCALE{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= out_next.valid;
    end
    out.bypass <= out_next.bypass;
    out.u      <= out_next.u;
    out.v      <= out_next.v;
    out.z      <= out_next.z;
  end

endmodule
`default_nettype wire

// File: rtl/pspm_cell.sv
// pspm_cell: one vectoring micro-rotation of the arctangent chain, registered.
// Depends on pspm_pkg; the shift and angle inputs are tied to constants per position.
`default_nettype none
module pspm_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [pspm_pkg::SHIFT_W-1:0]  shift,
  input  wire logic [pspm_pkg::TURN_W-1:0]   angle,
  input  wire pspm_pkg::stage_t              d_in,
  output pspm_pkg::stage_t                   d_out
);

  logic signed [pspm_pkg::DATA_W-1:0] du;
  logic signed [pspm_pkg::DATA_W-1:0] dv;
  pspm_pkg::stage_t                   d_next;

  always_comb begin
    // arithmetic shift is a floor division by 2^shift
    du = d_in.v >>> shift;
    dv = d_in.u >>> shift;
    d_next = d_in;
    if (!d_in.bypass) begin
      if (!d_in.v[pspm_pkg::DATA_W-1]) begin
        d_next.u = d_in.u + du;
        d_next.v = d_in.v - dv;
        d_next.z = d_in.z + angle;
      end else begin
        d_next.u = d_in.u - du;
        d_next.v = d_in.v + dv;
        d_next.z = d_in.z - angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else begin
      d_out.valid <= d_next.valid;
    end
    d_out.bypass <= d_next.bypass;
    d_out.u      <= d_next.u;
    d_out.v      <= d_next.v;
    d_out.z      <= d_next.z;
  end

endmodule
`default_nettype wire

// File: rtl/pspm_final.sv
// pspm_final: rounds the angle to a turn fraction and tests it against the sector.
// Depends on pspm_pkg; takes the last rotation cell and drives the result register.
`default_nettype none
module pspm_final (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pspm_pkg::stage_t  d_in,
  input  wire pspm_pkg::cfg_t    cfg,
  output logic                   done,
  output pspm_pkg::result_t      result
);

  localparam int AB  = pspm_pkg::ANGLE_BITS;
  localparam int TW  = pspm_pkg::TURN_W;
  localparam int CMP_W = AB + pspm_pkg::PCT_W;
  localparam logic [pspm_pkg::PCT_W-1:0] HUNDRED = pspm_pkg::PCT_W'(100);

  logic [TW-1:0]               rounded;
  logic [AB-1:0]               frac;
  logic [pspm_pkg::PCT_W-1:0]  pct;
  logic [CMP_W-1:0]            lhs;
  logic [CMP_W-1:0]            rhs;
  logic                        below;
  pspm_pkg::result_t           result_next;

  always_comb begin
    // round half up; a full turn wraps to zero
    rounded = d_in.z + (TW'(1) << (TW - 1 - AB));
    frac    = rounded[TW-1 -: AB];
    pct     = (cfg.used_percent > HUNDRED) ? HUNDRED : cfg.used_percent;
    lhs     = CMP_W'(frac) * CMP_W'(100);
    rhs     = CMP_W'(HUNDRED - pct) << AB;
    below   = lhs < rhs;
    result_next.keep          = cfg.keep_below ? below : !below;
    result_next.turn_fraction = pspm_pkg::FRAC_W'(frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_in.valid;
    end
    result <= result_next;
  end

endmodule
`default_nettype wire

// File: rtl/pie_sector_pixel_mask.sv
// Pie-sector pixel mask: one pixel enters per clock and its result leaves on done
// for exactly one cycle; the path is a preparation register, a row of 28 CORDIC
// rotation cells and an output register, so throughput is one per clock.
// busy is high only during reset. Configuration writes should be made with no pixel
// in flight; cfg_ready is high outside reset. Depends on pspm_pkg and the pspm modules.
`default_nettype none
module pie_sector_pixel_mask (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire pspm_pkg::pixel_t                  pixel,
  output logic                                   done,
  output pspm_pkg::result_t                      result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pspm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pspm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pspm_pkg::cfg_t   cfg;
  pspm_pkg::stage_t chain [pspm_pkg::CORDIC_STEPS+1];
  logic             accept;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= pspm_pkg::DIM_W'(64);
      cfg.image_height <= pspm_pkg::DIM_W'(64);
      cfg.used_percent <= '0;
      cfg.keep_below   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pspm_pkg::CFG_IMAGE_WIDTH: begin
          cfg.image_width <= cfg_data[pspm_pkg::DIM_W-1:0];
        end
        pspm_pkg::CFG_IMAGE_HEIGHT: begin
          cfg.image_height <= cfg_data[pspm_pkg::DIM_W-1:0];
        end
        pspm_pkg::CFG_USED_PERCENT: begin
          cfg.used_percent <= cfg_data[pspm_pkg::PCT_W-1:0];
        end
        pspm_pkg::CFG_KEEP_BELOW: begin
          cfg.keep_below <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  pspm_prep u_prep (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pixel  (pixel),
    .cfg    (cfg),
    .out    (chain[0])
  );

  for (genvar i = 0; i < pspm_pkg::CORDIC_STEPS; i++) begin : g_cell
    pspm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (pspm_pkg::SHIFT_W'(i)),
      .angle (pspm_pkg::atan_turn(i)),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  pspm_final u_final (
    .clk    (clk),
    .rst    (rst),
    .d_in   (chain[pspm_pkg::CORDIC_STEPS]),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

`ifndef SYNTH
  // every transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(pspm_pkg::LATENCY) done)
    else $error("accepted pixel produced no result");

  // no result without a transaction that fed it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, pspm_pkg::LATENCY))
    else $error("result without a matching pixel");

  // a pixel leaving the last rotation cell shows on done in the next cycle
  a_chain_end: assert property (@(posedge clk) disable iff (rst)
    chain[pspm_pkg::CORDIC_STEPS].valid |=> done)
    else $error("last cell valid not followed by done");
`endif

endmodule
`default_nettype wire
